@@ hdl/ksar_pkg.sv @@
// ----------------------------------------------------------------------------
// ksar_pkg
// Shared types, field layouts and codes of the key and stick auto repeat core.
// ----------------------------------------------------------------------------
package ksar_pkg;

    localparam int TIMER_BITS_DEFAULT = 24;
    localparam int REG_W              = 24;
    localparam int DZ_W               = 15;
    localparam int ELAPSED_W          = 16;
    localparam int AXIS_W             = 16;
    localparam int CFG_INDEX_W        = 2;
    localparam int IN_TDATA_W         = 72;
    localparam int OUT_TDATA_W        = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_DELAY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_RATE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEAD_ZONE    = 2'd2;

    localparam logic [REG_W-1:0] RESET_DELAY     = 24'd400000;
    localparam logic [REG_W-1:0] RESET_RATE      = 24'd100000;
    localparam logic [DZ_W-1:0]  RESET_DEAD_ZONE = 15'd16384;

    localparam logic [2:0] HELD_NONE = 3'd4;

    localparam logic [1:0] DIR_ROW_BACK   = 2'd0;
    localparam logic [1:0] DIR_ROW_FWD    = 2'd1;
    localparam logic [1:0] DIR_STEP_BACK  = 2'd2;
    localparam logic [1:0] DIR_STEP_FWD   = 2'd3;

    localparam int ARROW_DOWN  = 0;
    localparam int ARROW_UP    = 1;
    localparam int ARROW_RIGHT = 2;
    localparam int ARROW_LEFT  = 3;

    typedef struct packed {
        logic [REG_W-1:0] repeat_delay_us;
        logic [REG_W-1:0] repeat_rate_us;
        logic [DZ_W-1:0]  stick_dead_zone;
    } cfg_t;

    // Declared from the highest field down; keys_pressed sits in the lowest bits.
    typedef struct packed {
        logic [ELAPSED_W-1:0]     elapsed_us;
        logic signed [AXIS_W-1:0] stick_y;
        logic signed [AXIS_W-1:0] stick_x;
        logic [3:0]               pad_buttons_down;
        logic                     pad_menu_pressed;
        logic                     pad_confirm_pressed;
        logic                     pad_present;
        logic                     enter_pressed;
        logic [3:0]               keys_down;
        logic [3:0]               keys_released;
        logic [3:0]               keys_pressed;
    } in_item_t;

    typedef struct packed {
        logic       move_valid;
        logic [1:0] move_dir;
        logic       close;
    } pad_result_t;

    typedef struct packed {
        logic [1:0] screen_mode;
        logic       close_request;
        logic [1:0] pad_move_dir;
        logic       pad_move_valid;
        logic [1:0] left_moves;
        logic [1:0] right_moves;
        logic [1:0] up_moves;
        logic [1:0] down_moves;
    } result_t;

endpackage

@@ hdl/ksar_hold_tick.sv @@
// ----------------------------------------------------------------------------
// ksar_hold_tick
// Adds the frame time to a hold timer with saturation and fires a repeat
// once delay plus rate is reached, taking the rate off the timer.
// ----------------------------------------------------------------------------
module ksar_hold_tick #(
    parameter int TIMER_BITS = ksar_pkg::TIMER_BITS_DEFAULT
) (
    input  logic [TIMER_BITS-1:0]          timer_in,
    input  logic [ksar_pkg::ELAPSED_W-1:0] elapsed_us,
    input  logic [ksar_pkg::REG_W-1:0]     repeat_delay_us,
    input  logic [ksar_pkg::REG_W-1:0]     repeat_rate_us,
    output logic                           fire,
    output logic [TIMER_BITS-1:0]          timer_out
);

    localparam int THR_W = ksar_pkg::REG_W + 1;
    localparam int CMP_W = (TIMER_BITS > THR_W) ? TIMER_BITS : THR_W;

    logic [TIMER_BITS:0]   sum;
    logic [TIMER_BITS-1:0] sat;
    logic [THR_W-1:0]      thr;

    assign sum = {1'b0, timer_in} + (TIMER_BITS + 1)'(elapsed_us);
    assign sat = sum[TIMER_BITS] ? '1 : sum[TIMER_BITS-1:0];
    assign thr = {1'b0, repeat_delay_us} + {1'b0, repeat_rate_us};
    assign fire = CMP_W'(sat) >= CMP_W'(thr);
    assign timer_out = fire ? (sat - TIMER_BITS'(repeat_rate_us)) : sat;

endmodule

@@ hdl/ksar_key_repeat.sv @@
// ----------------------------------------------------------------------------
// ksar_key_repeat
// Typematic repeat of the four arrow keys with one shared held-key register
// and one shared hold timer, keys taken in the order down, up, right, left.
// ----------------------------------------------------------------------------
module ksar_key_repeat #(
    parameter int TIMER_BITS = ksar_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           advance,
    input  ksar_pkg::cfg_t                 cfg,
    input  logic [3:0]                     keys_pressed,
    input  logic [3:0]                     keys_released,
    input  logic [3:0]                     keys_down,
    input  logic [ksar_pkg::ELAPSED_W-1:0] elapsed_us,
    output logic [3:0][1:0]                moves
);

    logic [2:0]            held_key_reg;
    logic [2:0]            held_key_next;
    logic [TIMER_BITS-1:0] timer_reg;
    logic [TIMER_BITS-1:0] timer_next;
    logic                  fire_held;
    logic [TIMER_BITS-1:0] timer_held;
    logic                  fire_fresh;
    logic [TIMER_BITS-1:0] timer_fresh;

    ksar_hold_tick #(.TIMER_BITS(TIMER_BITS)) u_tick_held (
        .timer_in        (timer_reg),
        .elapsed_us      (elapsed_us),
        .repeat_delay_us (cfg.repeat_delay_us),
        .repeat_rate_us  (cfg.repeat_rate_us),
        .fire            (fire_held),
        .timer_out       (timer_held)
    );

    // A key pressed this frame starts its timer at zero before timing.
    ksar_hold_tick #(.TIMER_BITS(TIMER_BITS)) u_tick_fresh (
        .timer_in        ('0),
        .elapsed_us      (elapsed_us),
        .repeat_delay_us (cfg.repeat_delay_us),
        .repeat_rate_us  (cfg.repeat_rate_us),
        .fire            (fire_fresh),
        .timer_out       (timer_fresh)
    );

    always_comb begin
        logic fresh;
        fresh = 1'b0;
        held_key_next = held_key_reg;
        timer_next = timer_reg;
        for (int k = 0; k < 4; k++) begin
            moves[k] = 2'd0;
            if (keys_pressed[k]) begin
                moves[k] = 2'd1;
                held_key_next = 3'(k);
                timer_next = '0;
                fresh = 1'b1;
            end
            if (held_key_next == 3'(k)) begin
                if (keys_released[k]) begin
                    held_key_next = ksar_pkg::HELD_NONE;
                end else if (keys_down[k]) begin
                    if (fresh) begin
                        moves[k] = moves[k] + {1'b0, fire_fresh};
                        timer_next = timer_fresh;
                    end else begin
                        moves[k] = moves[k] + {1'b0, fire_held};
                        timer_next = timer_held;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_key_reg <= ksar_pkg::HELD_NONE;
            timer_reg <= '0;
        end else if (advance) begin
            held_key_reg <= held_key_next;
            timer_reg <= timer_next;
        end
    end

endmodule

@@ hdl/ksar_pad_repeat.sv @@
// ----------------------------------------------------------------------------
// ksar_pad_repeat
// Picks one gamepad direction by priority from the buttons and the stick
// with a dead zone, and repeats it with its own hold timer.
// ----------------------------------------------------------------------------
module ksar_pad_repeat #(
    parameter int TIMER_BITS = ksar_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               advance,
    input  ksar_pkg::cfg_t                     cfg,
    input  logic                               pad_present,
    input  logic                               pad_menu_pressed,
    input  logic [3:0]                         pad_buttons_down,
    input  logic signed [ksar_pkg::AXIS_W-1:0] stick_x,
    input  logic signed [ksar_pkg::AXIS_W-1:0] stick_y,
    input  logic [ksar_pkg::ELAPSED_W-1:0]     elapsed_us,
    output ksar_pkg::pad_result_t              result
);

    localparam int AW = ksar_pkg::AXIS_W + 1;

    logic [2:0]            held_dir_reg;
    logic [2:0]            held_dir_next;
    logic [TIMER_BITS-1:0] timer_reg;
    logic [TIMER_BITS-1:0] timer_next;
    logic                  fire;
    logic [TIMER_BITS-1:0] timer_ticked;
    logic signed [AW-1:0]  sx;
    logic signed [AW-1:0]  sy;
    logic signed [AW-1:0]  dz_pos;
    logic signed [AW-1:0]  dz_neg;
    logic [2:0]            dir;

    ksar_hold_tick #(.TIMER_BITS(TIMER_BITS)) u_tick (
        .timer_in        (timer_reg),
        .elapsed_us      (elapsed_us),
        .repeat_delay_us (cfg.repeat_delay_us),
        .repeat_rate_us  (cfg.repeat_rate_us),
        .fire            (fire),
        .timer_out       (timer_ticked)
    );

    assign sx = {stick_x[ksar_pkg::AXIS_W-1], stick_x};
    assign sy = {stick_y[ksar_pkg::AXIS_W-1], stick_y};
    assign dz_pos = $signed({2'b00, cfg.stick_dead_zone});
    assign dz_neg = -dz_pos;

    always_comb begin
        if (pad_buttons_down[ksar_pkg::ARROW_DOWN] || (sy > dz_pos)) begin
            dir = {1'b0, ksar_pkg::DIR_ROW_FWD};
        end else if (pad_buttons_down[ksar_pkg::ARROW_UP] || (sy < dz_neg)) begin
            dir = {1'b0, ksar_pkg::DIR_ROW_BACK};
        end else if (pad_buttons_down[ksar_pkg::ARROW_RIGHT] || (sx > dz_pos)) begin
            dir = {1'b0, ksar_pkg::DIR_STEP_FWD};
        end else if (pad_buttons_down[ksar_pkg::ARROW_LEFT] || (sx < dz_neg)) begin
            dir = {1'b0, ksar_pkg::DIR_STEP_BACK};
        end else begin
            dir = ksar_pkg::HELD_NONE;
        end
    end

    always_comb begin
        result = '0;
        held_dir_next = held_dir_reg;
        timer_next = timer_reg;
        if (pad_present) begin
            result.close = pad_menu_pressed;
            if (dir != ksar_pkg::HELD_NONE) begin
                if (held_dir_reg != dir) begin
                    result.move_valid = 1'b1;
                    held_dir_next = dir;
                    timer_next = '0;
                end else begin
                    result.move_valid = fire;
                    timer_next = timer_ticked;
                end
                result.move_dir = result.move_valid ? dir[1:0] : ksar_pkg::DIR_ROW_BACK;
            end else begin
                held_dir_next = ksar_pkg::HELD_NONE;
                timer_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_dir_reg <= ksar_pkg::HELD_NONE;
            timer_reg <= '0;
        end else if (advance) begin
            held_dir_reg <= held_dir_next;
            timer_reg <= timer_next;
        end
    end

endmodule

@@ hdl/key_and_stick_auto_repeat_core.sv @@
// ----------------------------------------------------------------------------
// key_and_stick_auto_repeat_core
// Arrow key typematic repeat, gamepad direction repeat and screen mode cycle.
// ----------------------------------------------------------------------------
// Path: an accepted request waits in the input register, then the result register.
// Throughput: one request per cycle unless a result is held by m_tready low; the
// registers are parted, so a request is taken while a finished result waits.
// Reset: aresetn low clears the valid flags of both registers, held keys, timers and the mode,
// and loads the configuration registers with their defaults.
module key_and_stick_auto_repeat_core #(
    parameter int TIMER_BITS = ksar_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [ksar_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ksar_pkg::REG_W-1:0]        cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // keys_pressed, keys_released, keys_down, enter_pressed, pad_present,
    // pad_confirm_pressed, pad_menu_pressed, pad_buttons_down, stick_x,
    // stick_y, elapsed_us, zero fill.
    input  logic [ksar_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // down_moves, up_moves, right_moves, left_moves, pad_move_valid,
    // pad_move_dir, close_request, screen_mode, zero fill.
    output logic [ksar_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    localparam int IN_W  = $bits(ksar_pkg::in_item_t);
    localparam int OUT_W = $bits(ksar_pkg::result_t);

    ksar_pkg::cfg_t          cfg_reg;
    ksar_pkg::in_item_t      in_reg;
    logic                    in_valid_reg;
    ksar_pkg::result_t       out_reg;
    ksar_pkg::result_t       out_next;
    logic                    out_valid_reg;
    logic                    advance;
    logic [1:0]              mode_reg;
    logic [1:0]              mode_next;
    logic                    mode_step;
    logic [3:0][1:0]         key_moves;
    ksar_pkg::pad_result_t   pad_res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(ksar_pkg::OUT_TDATA_W - OUT_W)'(0), out_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.repeat_delay_us <= ksar_pkg::RESET_DELAY;
            cfg_reg.repeat_rate_us  <= ksar_pkg::RESET_RATE;
            cfg_reg.stick_dead_zone <= ksar_pkg::RESET_DEAD_ZONE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ksar_pkg::CFG_REPEAT_DELAY: begin
                    cfg_reg.repeat_delay_us <= cfg_wdata;
                end
                ksar_pkg::CFG_REPEAT_RATE: begin
                    cfg_reg.repeat_rate_us <= cfg_wdata;
                end
                ksar_pkg::CFG_DEAD_ZONE: begin
                    cfg_reg.stick_dead_zone <= cfg_wdata[ksar_pkg::DZ_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg <= ksar_pkg::in_item_t'(s_tdata[IN_W-1:0]);
        end
    end

    ksar_key_repeat #(.TIMER_BITS(TIMER_BITS)) u_keys (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .cfg           (cfg_reg),
        .keys_pressed  (in_reg.keys_pressed),
        .keys_released (in_reg.keys_released),
        .keys_down     (in_reg.keys_down),
        .elapsed_us    (in_reg.elapsed_us),
        .moves         (key_moves)
    );

    ksar_pad_repeat #(.TIMER_BITS(TIMER_BITS)) u_pad (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .advance          (advance),
        .cfg              (cfg_reg),
        .pad_present      (in_reg.pad_present),
        .pad_menu_pressed (in_reg.pad_menu_pressed),
        .pad_buttons_down (in_reg.pad_buttons_down),
        .stick_x          (in_reg.stick_x),
        .stick_y          (in_reg.stick_y),
        .elapsed_us       (in_reg.elapsed_us),
        .result           (pad_res)
    );

    assign mode_step = in_reg.enter_pressed
                       || (in_reg.pad_present && in_reg.pad_confirm_pressed);
    assign mode_next = mode_step ? (mode_reg + 2'd1) : mode_reg;

    always_comb begin
        out_next.down_moves     = key_moves[ksar_pkg::ARROW_DOWN];
        out_next.up_moves       = key_moves[ksar_pkg::ARROW_UP];
        out_next.right_moves    = key_moves[ksar_pkg::ARROW_RIGHT];
        out_next.left_moves     = key_moves[ksar_pkg::ARROW_LEFT];
        out_next.pad_move_valid = pad_res.move_valid;
        out_next.pad_move_dir   = pad_res.move_dir;
        out_next.close_request  = pad_res.close;
        out_next.screen_mode    = mode_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                mode_reg <= mode_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !in_valid_reg)
        else $error("result or input register valid after reset");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a blocked result");

    a_mode_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(advance && mode_step) |=> $stable(mode_reg))
        else $error("screen mode changed without a confirm request");

    a_moves_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_reg.down_moves != 2'd3 && out_reg.up_moves != 2'd3
                     && out_reg.right_moves != 2'd3 && out_reg.left_moves != 2'd3)
        else $error("more than two moves for one key");

    a_pad_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !out_reg.pad_move_valid |-> out_reg.pad_move_dir == ksar_pkg::DIR_ROW_BACK)
        else $error("pad direction shown without a pad move");

endmodule
